// ----- src/slpp_pkg.sv -----
// ----------------------------------------------------------------------------
// slpp_pkg
// Shared types, constants and the cosine table builder for the pattern
// pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slpp_pkg;

  // line and table geometry
  localparam int unsigned LINE_LENGTH_MAX = 4096;
  localparam int unsigned COS_TABLE_BITS  = 10;
  localparam int unsigned TBL_N           = 1 << COS_TABLE_BITS;
  localparam int unsigned K_SHIFT         = 30 - COS_TABLE_BITS;

  // cosine magnitude in q1.30, 1.0 needs bit 30
  localparam int unsigned MAG_W = 31;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;

  // register reset values
  localparam logic [31:0] PHASE_INC_RST = 32'((64'd1 << 32) / LINE_LENGTH_MAX);
  localparam logic [4:0]  BIT_COUNT_RST = 5'($clog2(LINE_LENGTH_MAX));

  // apb address width, registers at 4*i
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    MODE_SINUSOID = 3'd0,
    MODE_GRAY     = 3'd1,
    MODE_GRAY_INV = 3'd2,
    MODE_ALL_ON   = 3'd3,
    MODE_ALL_OFF  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_PHASE_INC = 3'd1,
    REG_PHASE_OFS = 3'd2,
    REG_BIT_COUNT = 3'd3,
    REG_BIT_PLANE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] phase_inc;
    logic [31:0] phase_ofs;
    logic [4:0]  bit_count;
    logic [3:0]  bit_plane;
  } cfg_t;

  // payload between the phase stage and the cosine stage
  typedef struct packed {
    logic [31:0] angle;
    logic        use_sin;
    logic [7:0]  level;
  } phase_t;

  typedef logic [MAG_W-1:0] cos_rom_t [TBL_N+1];

  // restoring long division, only evaluated while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(x) with x in q2.30 radians, horner series to x^12, truncating steps
  function automatic logic [MAG_W-1:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] dv;
    x2 = (x * x) >> 30;
    r  = 64'(Q30_ONE);
    for (int i = 0; i < 6; i++) begin
      case (i)
        0:       dv = 64'd132;
        1:       dv = 64'd90;
        2:       dv = 64'd56;
        3:       dv = 64'd30;
        4:       dv = 64'd12;
        default: dv = 64'd2;
      endcase
      t = udiv64((x2 * r) >> 30, dv);
      r = (t >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - t;
    end
    return r[MAG_W-1:0];
  endfunction

  // quarter wave, TBL_N+1 entries
  function automatic cos_rom_t cos_rom_init();
    cos_rom_t rom;
    for (int k = 0; k <= int'(TBL_N); k++) begin
      rom[k] = cos_q30((64'(k) * HALF_PI_Q30) >> COS_TABLE_BITS);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- src/slpp_regs.sv -----
// ----------------------------------------------------------------------------
// slpp_regs
// APB register file holding the pattern configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module slpp_regs
  import slpp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE:      cfg_d.mode      = pwdata[2:0];
        REG_PHASE_INC: cfg_d.phase_inc = pwdata;
        REG_PHASE_OFS: cfg_d.phase_ofs = pwdata;
        REG_BIT_COUNT: cfg_d.bit_count = pwdata[4:0];
        REG_BIT_PLANE: cfg_d.bit_plane = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:      prdata = {29'd0, cfg_q.mode};
      REG_PHASE_INC: prdata = cfg_q.phase_inc;
      REG_PHASE_OFS: prdata = cfg_q.phase_ofs;
      REG_BIT_COUNT: prdata = {27'd0, cfg_q.bit_count};
      REG_BIT_PLANE: prdata = {28'd0, cfg_q.bit_plane};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_SINUSOID;
      cfg_q.phase_inc <= PHASE_INC_RST;
      cfg_q.phase_ofs <= 32'd0;
      cfg_q.bit_count <= BIT_COUNT_RST;
      cfg_q.bit_plane <= 4'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/slpp_phase.sv -----
// ----------------------------------------------------------------------------
// slpp_phase
// Phase angle of the pixel, gray code plane bit and mode level.
// ----------------------------------------------------------------------------
`default_nettype none

module slpp_phase
  import slpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] idx_i,
  input  wire cfg_t        cfg_i,
  output phase_t           stage_o
);

  phase_t      stage_q, stage_d;
  logic [47:0] prod;
  logic [15:0] gray;
  logic [6:0]  pos;
  logic        plane_bit;

  assign prod = 48'(idx_i) * 48'(cfg_i.phase_inc);
  assign gray = idx_i ^ (idx_i >> 1);

  // signed plane position, negative or above bit 15 reads zero
  assign pos       = 7'(cfg_i.bit_count) - 7'd1 - 7'(cfg_i.bit_plane);
  assign plane_bit = (!pos[6] && pos[5:4] == 2'd0) ? gray[pos[3:0]] : 1'b0;

  always_comb begin
    stage_d.angle   = prod[31:0] - cfg_i.phase_ofs;
    stage_d.use_sin = 1'b0;
    case (mode_e'(cfg_i.mode))
      MODE_SINUSOID: begin
        stage_d.use_sin = 1'b1;
        stage_d.level   = 8'd0;
      end
      MODE_GRAY:     stage_d.level = plane_bit ? 8'hff : 8'h00;
      MODE_GRAY_INV: stage_d.level = plane_bit ? 8'h00 : 8'hff;
      MODE_ALL_ON:   stage_d.level = 8'hff;
      default:       stage_d.level = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- src/slpp_cos.sv -----
// ----------------------------------------------------------------------------
// slpp_cos
// Quarter-wave cosine lookup and scaling to an 8-bit gray level; other modes pass their level through.
// ----------------------------------------------------------------------------
`default_nettype none

module slpp_cos
  import slpp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire phase_t     stage_i,
  output logic      [7:0] intensity_o
);

  localparam cos_rom_t COS_ROM = cos_rom_init();

  logic [1:0]                quad;
  logic [30:0]               p_rnd;
  logic [COS_TABLE_BITS:0]   k;
  logic [COS_TABLE_BITS:0]   addr;
  logic [MAG_W-1:0]          mag_q;
  logic                      neg_q;
  logic                      use_sin_q;
  logic [7:0]                level_q;
  logic [31:0]               num;
  logic [39:0]               scaled;
  logic [8:0]                sin_val;

  assign quad  = stage_i.angle[31:30];
  assign p_rnd = {1'b0, stage_i.angle[29:0]} + (31'd1 << (K_SHIFT - 1));
  assign k     = p_rnd[30:K_SHIFT];
  // odd quadrants walk the table backward
  assign addr  = quad[0] ? (COS_TABLE_BITS+1)'(TBL_N) - k : k;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q     <= COS_ROM[addr];
      neg_q     <= quad[0] ^ quad[1];
      use_sin_q <= stage_i.use_sin;
      level_q   <= stage_i.level;
    end
  end

  assign num     = neg_q ? Q30_ONE - 32'(mag_q) : Q30_ONE + 32'(mag_q);
  assign scaled  = (40'(num) << 8) - 40'(num);
  assign sin_val = scaled[39:31];

  always_comb begin
    if (!use_sin_q) begin
      intensity_o = level_q;
    end else if (sin_val[8]) begin
      intensity_o = 8'hff;
    end else begin
      intensity_o = sin_val[7:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/structured_light_pattern_pixel.sv -----
// ----------------------------------------------------------------------------
// structured_light_pattern_pixel
// Gives the 8-bit gray level of a sinusoid fringe, gray code plane or
// constant pattern for a pixel index along the projector axis.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tdata[15:0] pixel_index
//  m_axis    out        tdata[7:0]  intensity
//  apb       in/out     mode, phase_increment, phase_offset, bit_count,
//                       bit_plane at byte addresses 0, 4, 8, 12, 16
//
//  one pixel per clock while m_axis is not stalled; four register stages,
//  which each pixel passes in turn on its way from s_axis to m_axis
//  stages: input register, angle (16x32 multiply), cosine rom read, output
//  each stage loads when empty or when the next one moves, so bubbles close
//  up under an output stall
//  reset clears all valid flags and sets the registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module structured_light_pattern_pixel
  import slpp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,  // [15:0] pixel_index
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [7:0]        m_axis_tdata   // [7:0] intensity
);

  cfg_t        cfg;
  phase_t      stage_b;
  logic [15:0] idx_q;
  logic [7:0]  level_c;
  logic [7:0]  out_q;
  logic        vld_a_q, vld_b_q, vld_c_q, vld_o_q;
  logic        rdy_a, rdy_b, rdy_c, rdy_o;

  slpp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rdy_o = !vld_o_q || m_axis_tready;
  assign rdy_c = !vld_c_q || rdy_o;
  assign rdy_b = !vld_b_q || rdy_c;
  assign rdy_a = !vld_a_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= s_axis_tvalid;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q;
      if (rdy_o) vld_o_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      idx_q <= s_axis_tdata;
    end
    if (rdy_o) begin
      out_q <= level_c;
    end
  end

  slpp_phase u_phase (
    .clk_i   (clk_i),
    .en_i    (rdy_b),
    .idx_i   (idx_q),
    .cfg_i   (cfg),
    .stage_o (stage_b)
  );

  slpp_cos u_cos (
    .clk_i       (clk_i),
    .en_i        (rdy_c),
    .stage_i     (stage_b),
    .intensity_o (level_c)
  );

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = vld_o_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ----- src/slpp_checker.sv -----
// ----------------------------------------------------------------------------
// slpp_checker
// Port-level checks of the pattern pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slpp_checker
  import slpp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [31:0]       pwdata,
  input wire logic [31:0]       prdata,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [7:0]        m_axis_tdata
);

  // input side only backs up when every stage and the output are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // a mode write reads back masked to three bits in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && !pwrite && paddr == 5'd0 && $past(rst_ni)
     && $past(psel && penable && pwrite && paddr == 5'd0))
    |-> prdata == {29'd0, $past(pwdata[2:0])})
    else $error("mode register readback mismatch");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed under stall");

  // the output is not valid in the cycle after reset is sampled low
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind structured_light_pattern_pixel slpp_checker u_slpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- verif/pattern_level_checker.sv -----
// ----------------------------------------------------------------------------
// pattern_level_checker
// Watches the register port and both pixel streams of the pattern pixel
// generator, works out the gray level of every accepted pixel request and
// compares it with the intensity that comes out, in order.
// ----------------------------------------------------------------------------
module pattern_level_checker
  import slpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] pixel_index
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [7:0]        m_axis_tdata,   // [7:0] intensity
  output int                pending_o,
  output int                mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned FRAC_SHIFT  = 30 - COS_TABLE_BITS;
  localparam int          REPORT_MAX  = 10;
  localparam logic [7:0]  LEVEL_WHITE = 8'd255;
  localparam logic [7:0]  LEVEL_BLACK = 8'd0;

  logic [30:0] quarter_cos [0:TBL_N];

  logic [2:0]  cfg_mode;
  logic [31:0] cfg_inc;
  logic [31:0] cfg_ofs;
  logic [4:0]  cfg_bits;
  logic [3:0]  cfg_plane;

  logic [7:0]  expected_levels [$];
  logic [7:0]  want_level;
  int          fail_count;

  // cos(x), x in q2.30 radians: nested series 1 - x^2/(2n(2n-1)) * (...), n = 6 down to 1
  function automatic logic [30:0] horner_cos(input logic [63:0] x);
    logic [63:0] x_sq;
    logic [63:0] acc;
    logic [63:0] term;
    x_sq = (x * x) >> 30;
    acc  = ONE_Q30;
    for (int n = 6; n >= 1; n--) begin
      term = ((x_sq * acc) >> 30) / 64'((2 * n) * (2 * n - 1));
      acc  = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    end
    return acc[30:0];
  endfunction

  initial begin
    for (int j = 0; j <= int'(TBL_N); j++) begin
      quarter_cos[j] = horner_cos((64'(j) * HALF_PI_Q30) >> COS_TABLE_BITS);
    end
  end

  function automatic logic [7:0] pattern_level(input logic [15:0] idx);
    logic [15:0]             gray;
    int                      plane_pos;
    logic                    code_bit;
    logic [31:0]             angle;
    logic [1:0]              quadrant;
    logic [30:0]             rounded;
    logic [COS_TABLE_BITS:0] slot;
    logic [30:0]             mag;
    logic [63:0]             scaled;
    logic [7:0]              level;
    gray      = idx ^ (idx >> 1);
    plane_pos = int'(cfg_bits) - 1 - int'(cfg_plane);
    code_bit  = 1'b0;
    // planes outside the code and positions above the index width read as zero
    if (plane_pos >= 0 && plane_pos < 16) code_bit = gray[plane_pos];
    case (cfg_mode)
      MODE_SINUSOID: begin
        angle    = 32'(64'(idx) * 64'(cfg_inc)) - cfg_ofs;
        quadrant = angle[31:30];
        rounded  = {1'b0, angle[29:0]} + (31'd1 << (FRAC_SHIFT - 1));
        slot     = rounded[30:FRAC_SHIFT];
        mag      = quadrant[0] ? quarter_cos[TBL_N - slot] : quarter_cos[slot];
        // second and third quadrants are negative
        scaled   = (quadrant[1] ^ quadrant[0]) ? ONE_Q30 - 64'(mag) : ONE_Q30 + 64'(mag);
        scaled   = (64'd255 * scaled) >> 31;
        level    = (scaled > 64'd255) ? LEVEL_WHITE : scaled[7:0];
      end
      MODE_GRAY:     level = code_bit ? LEVEL_WHITE : LEVEL_BLACK;
      MODE_GRAY_INV: level = code_bit ? LEVEL_BLACK : LEVEL_WHITE;
      MODE_ALL_ON:   level = LEVEL_WHITE;
      default:       level = LEVEL_BLACK;
    endcase
    return level;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode   = MODE_SINUSOID;
      cfg_inc    = 32'((64'd1 << 32) / LINE_LENGTH_MAX);
      cfg_ofs    = '0;
      cfg_bits   = 5'($clog2(LINE_LENGTH_MAX));
      cfg_plane  = '0;
      fail_count = 0;
      expected_levels.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_MODE:      cfg_mode  = pwdata[2:0];
          REG_PHASE_INC: cfg_inc   = pwdata;
          REG_PHASE_OFS: cfg_ofs   = pwdata;
          REG_BIT_COUNT: cfg_bits  = pwdata[4:0];
          REG_BIT_PLANE: cfg_plane = pwdata[3:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_levels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: intensity %0d arrived with no request outstanding",
                     $time, m_axis_tdata);
          end
        end else begin
          want_level = expected_levels.pop_front();
          if (m_axis_tdata !== want_level) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: intensity mismatch, expected %0d, got %0d",
                       $time, want_level, m_axis_tdata);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_levels.insert(expected_levels.size(), pattern_level(s_axis_tdata));
      end
      pending_o    <= expected_levels.size();
      mismatches_o <= fail_count;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel requests and register settings into the pattern pixel
// generator under random source gaps and sink stalls; a checker beside the
// block predicts every intensity and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slpp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES  = 30;
  localparam int unsigned PHASE_ITEMS    = 50;
  localparam int unsigned WAIT_MAX       = 14;
  localparam logic [2:0]  MODE_LAST_CODE   = 3'd7;
  localparam logic [2:0]  REG_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  REG_UNUSED_LAST  = 3'd7;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;   // [15:0] pixel_index
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;         // [7:0] intensity

  int unsigned send_gap_max   = WAIT_MAX;
  int unsigned recv_stall_max = WAIT_MAX;
  int unsigned idle_cycles    = 0;
  int          pending_requests;
  int          mismatches;

  structured_light_pattern_pixel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pattern_level_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending_requests),
    .mismatches_o  (mismatches)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // sink side: random stall before each intensity
  initial begin : intensity_sink
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_pixel(input logic [15:0] idx);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off requests until every intensity is out and the pipe is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_requests != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_pattern();
    logic [2:0]  mode_v;
    logic [31:0] inc_v;
    logic [31:0] ofs_v;
    logic [4:0]  bits_v;
    int unsigned pick;
    int unsigned steps;
    pick = $urandom_range(0, 9);
    if (pick < 4) mode_v = MODE_SINUSOID;
    else if (pick < 6) mode_v = MODE_GRAY;
    else if (pick < 8) mode_v = MODE_GRAY_INV;
    else mode_v = 3'($urandom_range(MODE_ALL_ON, MODE_LAST_CODE));
    case ($urandom_range(0, 4))
      0:       inc_v = '0;
      1:       inc_v = '1;
      2:       inc_v = $urandom();
      default: inc_v = 32'((64'd1 << 32) * $urandom_range(1, 16) /
                           $urandom_range(2, LINE_LENGTH_MAX));
    endcase
    steps = $urandom_range(3, 8);
    case ($urandom_range(0, 4))
      0:       ofs_v = '0;
      1:       ofs_v = '1;
      2:       ofs_v = $urandom();
      default: ofs_v = 32'((64'd1 << 32) * $urandom_range(0, steps - 1) / steps);
    endcase
    case ($urandom_range(0, 5))
      0:       bits_v = '0;
      1:       bits_v = 5'($urandom_range(17, 31));
      default: bits_v = 5'($urandom_range(1, 16));
    endcase
    // upper bits of the mode, bit count and bit plane writes are junk and must be dropped
    write_reg(REG_MODE,      {29'($urandom()), mode_v});
    write_reg(REG_PHASE_INC, inc_v);
    write_reg(REG_PHASE_OFS, ofs_v);
    write_reg(REG_BIT_COUNT, {27'($urandom()), bits_v});
    write_reg(REG_BIT_PLANE, {28'($urandom()), 4'($urandom_range(0, 15))});
    if ($urandom_range(0, 7) == 0) begin
      write_reg(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom());
    end
    case ($urandom_range(0, 3))
      0:       send_gap_max = 0;
      1:       send_gap_max = 2;
      default: send_gap_max = WAIT_MAX;
    endcase
    case ($urandom_range(0, 3))
      0:       recv_stall_max = 0;
      1:       recv_stall_max = 2;
      default: recv_stall_max = WAIT_MAX;
    endcase
  endtask

  initial begin : stimulus
    logic [15:0] idx;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fringe with reset settings, across the quarter points and index ends
    send_pixel(16'd0);
    send_pixel(16'd1);
    send_pixel(16'd1024);
    send_pixel(16'd2048);
    send_pixel(16'd3072);
    send_pixel(16'hFFFF);

    // angle steps just past the start of the fourth quadrant
    settle();
    write_reg(REG_PHASE_INC, 32'd1);
    write_reg(REG_PHASE_OFS, 32'h3FFF_8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h8001);

    settle();
    write_reg(REG_PHASE_INC, '1);
    write_reg(REG_PHASE_OFS, '1);
    send_pixel(16'd0);
    send_pixel(16'hFFFF);

    // gray planes, top and bottom of the code
    settle();
    write_reg(REG_MODE, 32'(MODE_GRAY));
    send_pixel(16'h0800);
    send_pixel(16'h07FF);
    settle();
    write_reg(REG_BIT_COUNT, 32'd16);
    write_reg(REG_BIT_PLANE, 32'd15);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    settle();
    write_reg(REG_MODE, 32'(MODE_GRAY_INV));
    write_reg(REG_BIT_PLANE, 32'd0);
    send_pixel(16'h8000);
    send_pixel(16'h0000);

    // plane outside the code, empty code, oversized code, single-bit code
    settle();
    write_reg(REG_MODE, 32'(MODE_GRAY));
    write_reg(REG_BIT_COUNT, 32'd4);
    write_reg(REG_BIT_PLANE, 32'd9);
    send_pixel(16'hFFFF);
    settle();
    write_reg(REG_BIT_COUNT, 32'd0);
    send_pixel(16'hFFFF);
    settle();
    write_reg(REG_BIT_COUNT, 32'd31);
    write_reg(REG_BIT_PLANE, 32'd0);
    send_pixel(16'hFFFF);
    settle();
    write_reg(REG_BIT_COUNT, 32'd1);
    send_pixel(16'h0001);

    // constant patterns, a write to an unused register and the last unused mode code
    settle();
    write_reg(REG_MODE, 32'(MODE_ALL_ON));
    write_reg(REG_UNUSED_FIRST, '1);
    send_pixel(16'h1234);
    settle();
    write_reg(REG_MODE, 32'(MODE_ALL_OFF));
    send_pixel(16'h1234);
    settle();
    write_reg(REG_MODE, 32'(MODE_LAST_CODE));
    send_pixel(16'hFFFF);

    for (int phase = 0; phase < int'(RANDOM_PHASES); phase++) begin
      settle();
      program_pattern();
      for (int i = 0; i < int'(PHASE_ITEMS); i++) begin
        if (phase % 5 == 0 && i == int'(PHASE_ITEMS) / 2) settle();
        if ($urandom_range(0, 1) == 0) idx = 16'($urandom());
        else idx = 16'($urandom_range(0, LINE_LENGTH_MAX - 1));
        send_pixel(idx);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
